// ===== src/bsid_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte stream instruction decoder package
// Shared types, opcode table and addressing-mode decode for the 6502 decoder.
// ----------------------------------------------------------------------------
package bsid_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE  = 1'b1;
  localparam logic [16:0] WINDOW_SIZE_RESET = 17'h10000;

  // Operation numbers that the decoder treats specially.
  localparam logic [6:0] OP_BRK  = 7'd0;
  localparam logic [6:0] OP_JSR  = 7'd1;
  localparam logic [6:0] OP_RTI  = 7'd2;
  localparam logic [6:0] OP_RTS  = 7'd3;
  localparam logic [6:0] OP_JMP  = 7'd4;
  localparam logic [6:0] OP_LDA  = 7'd53;
  localparam logic [6:0] OP_STA  = 7'd54;
  localparam logic [6:0] OP_LDX  = 7'd55;
  localparam logic [6:0] OP_STX  = 7'd56;
  localparam logic [6:0] OP_LDY  = 7'd57;
  localparam logic [6:0] OP_STY  = 7'd58;
  localparam logic [6:0] OP_NONE = 7'd74;

  // Opcode bytes that pick an addressing mode of their own.
  localparam logic [7:0] OPC_JSR     = 8'h20;
  localparam logic [7:0] OPC_JMP_IND = 8'h6c;
  localparam logic [7:0] OPC_STX_ZPY = 8'h96;
  localparam logic [7:0] OPC_LDX_ZPY = 8'hb6;
  localparam logic [7:0] OPC_SAX_ZPY = 8'h97;
  localparam logic [7:0] OPC_LAX_ZPY = 8'hb7;
  localparam logic [7:0] OPC_SHX_ABY = 8'h9e;
  localparam logic [7:0] OPC_LDX_ABY = 8'hbe;
  localparam logic [7:0] OPC_AHX_ABY = 8'h9f;
  localparam logic [7:0] OPC_LAX_ABY = 8'hbf;

  typedef enum logic [3:0] {
    MODE_IMP = 4'd0,
    MODE_IMM = 4'd1,
    MODE_ABS = 4'd2,
    MODE_REL = 4'd3,
    MODE_ZP  = 4'd4,
    MODE_ZPX = 4'd5,
    MODE_ZPY = 4'd6,
    MODE_ABX = 4'd7,
    MODE_ABY = 4'd8,
    MODE_IZX = 4'd9,
    MODE_IZY = 4'd10,
    MODE_IND = 4'd11
  } mode_t;

  typedef enum logic [2:0] {
    FLOW_CONTINUE = 3'd0,
    FLOW_STOP     = 3'd1,
    FLOW_CALL     = 3'd2,
    FLOW_JUMP_ABS = 3'd3,
    FLOW_JUMP_IND = 3'd4,
    FLOW_BRANCH   = 3'd5
  } flow_t;

  // A complete instruction handed from the byte sequencer to the classifier.
  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] operand;
    logic [15:0] after;
    logic [15:0] opaddr;
  } item_t;

  // One decoded instruction record.
  typedef struct packed {
    logic [15:0] instr_address;
    logic [6:0]  operation;
    logic [3:0]  addr_mode;
    logic [15:0] operand_value;
    logic [2:0]  flow_kind;
    logic [15:0] target_address;
    logic        target_outside;
    logic        external_load;
    logic        external_store;
  } result_t;

  // Operation number for each opcode byte.
  localparam logic [6:0] OP_TABLE [256] = '{
    7'd0,7'd38,7'd74,7'd34,7'd59,7'd38,7'd45,7'd34,
    7'd26,7'd38,7'd45,7'd64,7'd59,7'd38,7'd45,7'd34,
    7'd5,7'd38,7'd74,7'd34,7'd59,7'd38,7'd45,7'd34,
    7'd27,7'd38,7'd59,7'd34,7'd59,7'd38,7'd45,7'd34,
    7'd1,7'd39,7'd74,7'd35,7'd41,7'd39,7'd46,7'd35,
    7'd25,7'd39,7'd46,7'd64,7'd41,7'd39,7'd46,7'd35,
    7'd6,7'd39,7'd74,7'd35,7'd59,7'd39,7'd46,7'd35,
    7'd28,7'd39,7'd59,7'd35,7'd59,7'd39,7'd46,7'd35,
    7'd2,7'd40,7'd74,7'd36,7'd59,7'd40,7'd47,7'd36,
    7'd24,7'd40,7'd47,7'd65,7'd4,7'd40,7'd47,7'd36,
    7'd7,7'd40,7'd74,7'd36,7'd59,7'd40,7'd47,7'd36,
    7'd31,7'd40,7'd59,7'd36,7'd59,7'd40,7'd47,7'd36,
    7'd3,7'd42,7'd74,7'd37,7'd59,7'd42,7'd48,7'd37,
    7'd23,7'd42,7'd48,7'd66,7'd4,7'd42,7'd48,7'd37,
    7'd8,7'd42,7'd74,7'd37,7'd59,7'd42,7'd48,7'd37,
    7'd32,7'd42,7'd59,7'd37,7'd59,7'd42,7'd48,7'd37,
    7'd59,7'd54,7'd59,7'd60,7'd58,7'd54,7'd56,7'd60,
    7'd14,7'd59,7'd18,7'd67,7'd58,7'd54,7'd56,7'd60,
    7'd9,7'd54,7'd74,7'd69,7'd58,7'd54,7'd56,7'd60,
    7'd20,7'd54,7'd22,7'd72,7'd70,7'd54,7'd71,7'd69,
    7'd57,7'd53,7'd55,7'd61,7'd57,7'd53,7'd55,7'd61,
    7'd19,7'd53,7'd17,7'd61,7'd57,7'd53,7'd55,7'd61,
    7'd10,7'd53,7'd74,7'd61,7'd57,7'd53,7'd55,7'd61,
    7'd33,7'd53,7'd21,7'd73,7'd57,7'd53,7'd55,7'd61,
    7'd50,7'd43,7'd59,7'd62,7'd50,7'd43,7'd51,7'd62,
    7'd16,7'd43,7'd13,7'd68,7'd50,7'd43,7'd51,7'd62,
    7'd11,7'd43,7'd74,7'd62,7'd59,7'd43,7'd51,7'd62,
    7'd29,7'd43,7'd59,7'd62,7'd59,7'd43,7'd51,7'd62,
    7'd49,7'd44,7'd59,7'd63,7'd49,7'd44,7'd52,7'd63,
    7'd15,7'd44,7'd59,7'd44,7'd49,7'd44,7'd52,7'd63,
    7'd12,7'd44,7'd74,7'd63,7'd59,7'd44,7'd52,7'd63,
    7'd30,7'd44,7'd59,7'd63,7'd59,7'd44,7'd52,7'd63
  };

  // Addressing mode of an opcode byte, mostly set by its low five bits.
  function automatic mode_t mode_of(input logic [7:0] op);
    mode_t m;
    case (op[4:0])
      5'h00: begin
        if (op[7]) m = MODE_IMM;
        else if (op == OPC_JSR) m = MODE_ABS;
        else m = MODE_IMP;
      end
      5'h08, 5'h18, 5'h0a, 5'h1a, 5'h12: m = MODE_IMP;
      5'h10: m = MODE_REL;
      5'h01, 5'h03: m = MODE_IZX;
      5'h02, 5'h09, 5'h0b: m = MODE_IMM;
      5'h04, 5'h05, 5'h06, 5'h07: m = MODE_ZP;
      5'h0c, 5'h0d, 5'h0e, 5'h0f: m = (op == OPC_JMP_IND) ? MODE_IND : MODE_ABS;
      5'h11, 5'h13: m = MODE_IZY;
      5'h14, 5'h15, 5'h16, 5'h17: begin
        if (op == OPC_STX_ZPY || op == OPC_LDX_ZPY || op == OPC_SAX_ZPY ||
            op == OPC_LAX_ZPY) m = MODE_ZPY;
        else m = MODE_ZPX;
      end
      5'h19, 5'h1b: m = MODE_ABY;
      default: begin
        if (op == OPC_SHX_ABY || op == OPC_LDX_ABY || op == OPC_AHX_ABY ||
            op == OPC_LAX_ABY) m = MODE_ABY;
        else m = MODE_ABX;
      end
    endcase
    return m;
  endfunction

  // Number of operand bytes that follow the opcode.
  function automatic logic [1:0] length_of(input mode_t m);
    logic [1:0] n;
    case (m)
      MODE_IMP: n = 2'd0;
      MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND: n = 2'd2;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== src/bsid_in_if.sv =====
// ----------------------------------------------------------------------------
// Program byte channel
// Valid/ready channel that carries one program byte per transfer.
// ----------------------------------------------------------------------------
interface bsid_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic        restart;
  logic [15:0] begin_address;

  modport source (output valid, output byte_value, output restart,
                  output begin_address, input ready);
  modport sink (input valid, input byte_value, input restart,
                input begin_address, output ready);
endinterface

// ===== src/bsid_out_if.sv =====
// ----------------------------------------------------------------------------
// Instruction record channel
// Valid/ready channel that carries one decoded instruction per transfer.
// ----------------------------------------------------------------------------
interface bsid_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_address;
  logic [6:0]  operation;
  logic [3:0]  addr_mode;
  logic [15:0] operand_value;
  logic [2:0]  flow_kind;
  logic [15:0] target_address;
  logic        target_outside;
  logic        external_load;
  logic        external_store;

  modport source (output valid, output instr_address, output operation,
                  output addr_mode, output operand_value, output flow_kind,
                  output target_address, output target_outside,
                  output external_load, output external_store, input ready);
  modport sink (input valid, input instr_address, input operation,
                input addr_mode, input operand_value, input flow_kind,
                input target_address, input target_outside,
                input external_load, input external_store, output ready);
endinterface

// ===== src/bsid_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes one configuration register per transfer.
// ----------------------------------------------------------------------------
interface bsid_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [16:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/bsid_classify.sv =====
// ----------------------------------------------------------------------------
// Instruction classifier
// Turns a complete instruction into its record: operation, mode, flow kind,
// destination and the memory window checks.
// ----------------------------------------------------------------------------
module bsid_classify (
  input  bsid_pkg::item_t   item,
  input  logic [15:0]       window_start,
  input  logic [16:0]       window_size,
  output bsid_pkg::result_t result
);

  logic [6:0]         op;
  bsid_pkg::mode_t    mode;
  bsid_pkg::flow_t    kind;
  logic [15:0]        target;
  logic [15:0]        branch_target;
  logic [17:0]        window_end;
  logic               target_out;
  logic               operand_out;
  logic               is_load;
  logic               is_store;

  // Opcode table and mode decode.
  assign op   = bsid_pkg::OP_TABLE[item.opcode];
  assign mode = bsid_pkg::mode_of(item.opcode);

  // Branch destination: address after the instruction plus the signed offset.
  assign branch_target = item.after + {{8{item.operand[7]}}, item.operand[7:0]};

  // Flow kind and destination.
  always_comb begin
    kind   = bsid_pkg::FLOW_CONTINUE;
    target = 16'h0000;
    if (op == bsid_pkg::OP_BRK || op == bsid_pkg::OP_RTI || op == bsid_pkg::OP_RTS) begin
      kind = bsid_pkg::FLOW_STOP;
    end else if (op == bsid_pkg::OP_JSR) begin
      kind   = bsid_pkg::FLOW_CALL;
      target = item.operand;
    end else if (op == bsid_pkg::OP_JMP) begin
      if (mode == bsid_pkg::MODE_ABS) begin
        kind   = bsid_pkg::FLOW_JUMP_ABS;
        target = item.operand;
      end else begin
        kind = bsid_pkg::FLOW_JUMP_IND;
      end
    end else if (mode == bsid_pkg::MODE_REL) begin
      kind   = bsid_pkg::FLOW_BRANCH;
      target = branch_target;
    end
  end

  // Window checks; the upper bound does not wrap.
  assign window_end  = {2'b00, window_start} + {1'b0, window_size};
  assign target_out  = (target < window_start) || ({2'b00, target} >= window_end);
  assign operand_out = (item.operand < window_start) ||
                       ({2'b00, item.operand} >= window_end);

  assign is_load  = (op == bsid_pkg::OP_LDA) || (op == bsid_pkg::OP_LDX) ||
                    (op == bsid_pkg::OP_LDY);
  assign is_store = (op == bsid_pkg::OP_STA) || (op == bsid_pkg::OP_STX) ||
                    (op == bsid_pkg::OP_STY);

  // Assemble the record.
  always_comb begin
    result.instr_address  = item.opaddr;
    result.operation      = op;
    result.addr_mode      = mode;
    result.operand_value  = item.operand;
    result.flow_kind      = kind;
    result.target_address = target;
    result.target_outside = target_out && (kind == bsid_pkg::FLOW_CALL ||
                                           kind == bsid_pkg::FLOW_JUMP_ABS ||
                                           kind == bsid_pkg::FLOW_BRANCH);
    result.external_load  = (mode == bsid_pkg::MODE_ABS) && operand_out && is_load;
    result.external_store = (mode == bsid_pkg::MODE_ABS) && operand_out && is_store;
  end

endmodule

// ===== src/byte_stream_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// Byte stream instruction decoder
// Streaming 6502 decoder: program bytes in, one record per instruction out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one program byte per transfer. With restart set, the byte
//   is an opcode at begin_address and any partial instruction is dropped;
//   otherwise its address is one past the previous byte's.
//   out_ch carries one record per complete instruction, sent after its last
//   byte (opcode for implied mode, else the last operand byte).
//   cfg_ch writes the memory window (index 0 start, index 1 size); it is
//   always ready and must be written only while the decoder is idle.
// Timing:
//   One byte per cycle is accepted while in_ch is ready. After the transfer
//   of its last byte, a record is taken by the sequencer register and then
//   by the output register behind the classifier before it is offered on out_ch.
// Reset and stalls:
//   Reset empties both registers, clears the sequencer and opens the window
//   over all 64K. While out_ch is stalled, one more record can wait in the
//   sequencer register; after that in_ch drops ready.
// ----------------------------------------------------------------------------
module byte_stream_instruction_decoder (
  input  logic              clk,
  input  logic              rst_n,
  bsid_in_if.sink           in_ch,
  bsid_out_if.source        out_ch,
  bsid_cfg_if.sink          cfg_ch
);

  logic [15:0]       window_start_r;
  logic [16:0]       window_size_r;

  logic [1:0]        pending_r, pending_nxt;
  logic [7:0]        held_opcode_r, held_opcode_nxt;
  logic [7:0]        low_byte_r, low_byte_nxt;
  logic [15:0]       opaddr_r, opaddr_nxt;
  logic [15:0]       next_addr_r, next_addr_nxt;

  bsid_pkg::item_t   item_r, item_nxt;
  logic              item_valid_r;
  logic              emit;

  bsid_pkg::result_t result;
  bsid_pkg::result_t out_r;
  logic              out_valid_r;

  logic              in_xfer;
  logic              advance;
  logic [15:0]       addr;
  logic [1:0]        pending_eff;
  logic [15:0]       offset;
  logic              in_window;
  logic [1:0]        opcode_len;
  logic              held_two;

  // Pipeline flow control.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !item_valid_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Address of the incoming byte and its window check.
  assign addr        = in_ch.restart ? in_ch.begin_address : next_addr_r;
  assign pending_eff = in_ch.restart ? 2'd0 : pending_r;
  assign offset      = addr - window_start_r;
  assign in_window   = {1'b0, offset} < window_size_r;
  assign opcode_len  = bsid_pkg::length_of(bsid_pkg::mode_of(in_ch.byte_value));
  assign held_two    = bsid_pkg::length_of(bsid_pkg::mode_of(held_opcode_r)) == 2'd2;

  // Byte sequencer: gather opcode and operand bytes.
  always_comb begin
    pending_nxt     = pending_r;
    held_opcode_nxt = held_opcode_r;
    low_byte_nxt    = low_byte_r;
    opaddr_nxt      = opaddr_r;
    next_addr_nxt   = next_addr_r;
    emit            = 1'b0;
    item_nxt.opcode  = held_opcode_r;
    item_nxt.operand = 16'h0000;
    item_nxt.after   = addr + 16'd1;
    item_nxt.opaddr  = opaddr_r;
    if (in_xfer) begin
      next_addr_nxt = addr + 16'd1;
      if (!in_window) begin
        pending_nxt = 2'd0;
      end else if (pending_eff == 2'd2) begin
        low_byte_nxt = in_ch.byte_value;
        pending_nxt  = 2'd1;
      end else if (pending_eff == 2'd1) begin
        pending_nxt = 2'd0;
        emit        = 1'b1;
        item_nxt.operand = held_two ? {in_ch.byte_value, low_byte_r}
                                    : {8'h00, in_ch.byte_value};
      end else begin
        held_opcode_nxt = in_ch.byte_value;
        opaddr_nxt      = addr;
        pending_nxt     = opcode_len;
        emit            = (opcode_len == 2'd0);
        item_nxt.opcode = in_ch.byte_value;
        item_nxt.opaddr = addr;
      end
    end
  end

  // Control registers: sequencer state, valid flags and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r      <= 2'd0;
      held_opcode_r  <= 8'h00;
      low_byte_r     <= 8'h00;
      opaddr_r       <= 16'h0000;
      next_addr_r    <= 16'h0000;
      item_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
      window_start_r <= 16'h0000;
      window_size_r  <= bsid_pkg::WINDOW_SIZE_RESET;
    end else begin
      pending_r     <= pending_nxt;
      held_opcode_r <= held_opcode_nxt;
      low_byte_r    <= low_byte_nxt;
      opaddr_r      <= opaddr_nxt;
      next_addr_r   <= next_addr_nxt;
      if (in_xfer) begin
        item_valid_r <= emit;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= item_valid_r;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          bsid_pkg::REG_WINDOW_START: window_start_r <= cfg_ch.data[15:0];
          bsid_pkg::REG_WINDOW_SIZE:  window_size_r  <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      item_r <= item_nxt;
    end
    if (advance && item_valid_r) begin
      out_r <= result;
    end
  end

  // Record decode between the sequencer and the output register.
  bsid_classify u_classify (
    .item         (item_r),
    .window_start (window_start_r),
    .window_size  (window_size_r),
    .result       (result)
  );

  // Port drive.
  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.instr_address  = out_r.instr_address;
  assign out_ch.operation      = out_r.operation;
  assign out_ch.addr_mode      = out_r.addr_mode;
  assign out_ch.operand_value  = out_r.operand_value;
  assign out_ch.flow_kind      = out_r.flow_kind;
  assign out_ch.target_address = out_r.target_address;
  assign out_ch.target_outside = out_r.target_outside;
  assign out_ch.external_load  = out_r.external_load;
  assign out_ch.external_store = out_r.external_store;

endmodule
